### rtl/core/skpl_pkg.sv
package skpl_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int ITEM_W   = 32;

	localparam logic [2:0] FN_PREPEND = 3'd0;
	localparam logic [2:0] FN_APPEND  = 3'd1;
	localparam logic [2:0] FN_RMHEAD  = 3'd2;
	localparam logic [2:0] FN_INSERT  = 3'd3;
	localparam logic [2:0] FN_REMOVE  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [ITEM_W-1:0]       item;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] key;
		logic [ITEM_W-1:0]       item;
		logic [CNT_W-1:0]        total;
	} res_t;

endpackage

### rtl/core/sorted_key_priority_list.sv
// Sorted key priority list: up to CAPACITY (key, item) entries in ascending key order.
// Input channel: in_valid/in_ready carry one word of func, key_in, item_in.
//   func selects prepend, append, remove head, sorted insert or sorted remove.
// Output channel: out_valid/out_ready carry one result word per input word:
//   status, key_out, item_out and entry_total after the operation.
// Entries live in one single-port-read, single-port-write memory, head at
// address 0, with a registered read port. Prepend, remove head and the sorted operations walk over it.
// Steps per word, from acceptance to the result entering the output register:
//   rejected words and unused codes go straight to the result; any insert into
//   an empty list writes address 0; prepend moves every entry up; append writes
//   after the tail; remove head moves the rest down; sorted insert/remove scan to
//   the key, then move the later entries; a sorted remove with no match only scans.
// A new word is taken in the cycle after the previous result enters the output
// register, even while that result still waits on out_ready.
// When the receiver stalls, the result holds in the output register and a
// second finished result waits inside the sequencer; in_ready stays low then.
// Reset clears the entry count and the control state; the memory is not
// cleared, since only entries below the count are ever used.
module sorted_key_priority_list
	import skpl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              func,
	input  logic signed [KEY_W-1:0] key_in,
	input  logic [ITEM_W-1:0]       item_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] key_out,
	output logic [ITEM_W-1:0]       item_out,
	output logic [CNT_W-1:0]        entry_total
);

	mem_req_t req;
	entry_t rdata;
	logic [ENTRY_W-1:0] rdata_raw;
	logic done_valid;
	logic done_take;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	skpl_ram #(
		.AW(IDX_W),
		.DW(ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (rdata_raw)
	);

	assign rdata = entry_t'(rdata_raw);

	skpl_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.key_in     (key_in),
		.item_in    (item_in),
		.rdata      (rdata),
		.req        (req),
		.done_valid (done_valid),
		.done_take  (done_take),
		.res        (res)
	);

	assign done_take = done_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign key_out     = out_q.key;
	assign item_out    = out_q.item;
	assign entry_total = out_q.total;

endmodule

### rtl/core/skpl_ram.sv
module skpl_ram #(
	parameter int AW = 4,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/skpl_seq.sv
module skpl_seq
	import skpl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              func,
	input  logic signed [KEY_W-1:0] key_in,
	input  logic [ITEM_W-1:0]       item_in,
	input  entry_t                  rdata,
	output mem_req_t                req,
	output logic                    done_valid,
	input  logic                    done_take,
	output res_t                    res
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_PKEV = 8'b00000010,
		S_SCEV = 8'b00000100,
		S_UPRD = 8'b00001000,
		S_UPWR = 8'b00010000,
		S_DNRD = 8'b00100000,
		S_DNWR = 8'b01000000,
		S_DONE = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [2:0] func_q, func_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic [ITEM_W-1:0] item_q, item_d;
	logic signed [KEY_W-1:0] kout_q, kout_d;
	logic [ITEM_W-1:0] iout_q, iout_d;
	logic [1:0] status_q, status_d;

	logic [CNT_W:0] idx_inc;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] idx_m1;
	logic cnt_full;
	logic signed [KEY_W-1:0] sat_dec;
	logic signed [KEY_W-1:0] sat_inc;

	assign idx_inc  = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign idx_m1   = idx_q - CNT_W'(1);
	assign cnt_full = (cnt_q == CNT_W'(CAPACITY));
	assign sat_dec  = (rdata.key == KEY_MIN) ? KEY_MIN : rdata.key - KEY_W'(1);
	assign sat_inc  = (rdata.key == KEY_MAX) ? KEY_MAX : rdata.key + KEY_W'(1);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		func_d    = func_q;
		key_d     = key_q;
		item_d    = item_q;
		kout_d    = kout_q;
		iout_d    = iout_q;
		status_d  = status_q;
		req.we    = 1'b0;
		req.waddr = idx_q[IDX_W-1:0];
		req.wdata = rdata;
		req.raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				req.raddr = (func == FN_APPEND) ? cnt_m1[IDX_W-1:0] : '0;
				if (in_valid) begin
					func_d   = func;
					key_d    = key_in;
					item_d   = item_in;
					kout_d   = '0;
					iout_d   = '0;
					status_d = ST_OK;
					idx_d    = '0;
					pos_d    = '0;
					case (func) inside
						FN_PREPEND, FN_APPEND, FN_INSERT: begin
							if (cnt_full) begin
								status_d = ST_FULL;
								state_d  = S_DONE;
							end else if (cnt_q == '0) begin
								if (func != FN_INSERT) begin
									key_d = '0;
								end
								kout_d  = (func == FN_INSERT) ? key_in : '0;
								state_d = S_UPRD;
							end else if (func == FN_INSERT) begin
								kout_d  = key_in;
								state_d = S_SCEV;
							end else begin
								state_d = S_PKEV;
							end
						end
						FN_RMHEAD, FN_REMOVE: begin
							if (cnt_q == '0) begin
								status_d = ST_MISS;
								state_d  = S_DONE;
							end else begin
								state_d = (func == FN_RMHEAD) ? S_PKEV : S_SCEV;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_PKEV: begin
				case (func_q)
					FN_PREPEND: begin
						key_d   = sat_dec;
						kout_d  = sat_dec;
						pos_d   = '0;
						idx_d   = cnt_q;
						state_d = S_UPRD;
					end
					FN_APPEND: begin
						key_d   = sat_inc;
						kout_d  = sat_inc;
						pos_d   = cnt_q;
						idx_d   = cnt_q;
						state_d = S_UPRD;
					end
					FN_RMHEAD: begin
						kout_d  = rdata.key;
						iout_d  = rdata.item;
						pos_d   = '0;
						idx_d   = '0;
						state_d = S_DNRD;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCEV: begin
				if (rdata.key < key_q) begin
					if (idx_inc == {1'b0, cnt_q}) begin
						if (func_q == FN_INSERT) begin
							pos_d   = cnt_q;
							idx_d   = cnt_q;
							state_d = S_UPRD;
						end else begin
							status_d = ST_MISS;
							state_d  = S_DONE;
						end
					end else begin
						idx_d     = idx_inc[CNT_W-1:0];
						req.raddr = idx_inc[IDX_W-1:0];
					end
				end else if (func_q == FN_INSERT) begin
					pos_d   = idx_q;
					idx_d   = cnt_q;
					state_d = S_UPRD;
				end else if (rdata.key == key_q) begin
					kout_d  = rdata.key;
					iout_d  = rdata.item;
					pos_d   = idx_q;
					state_d = S_DNRD;
				end else begin
					status_d = ST_MISS;
					state_d  = S_DONE;
				end
			end
			S_UPRD: begin
				if (idx_q == pos_q) begin
					req.we    = 1'b1;
					req.waddr = pos_q[IDX_W-1:0];
					req.wdata = '{key: key_q, item: item_q};
					cnt_d     = cnt_q + CNT_W'(1);
					state_d   = S_DONE;
				end else begin
					req.raddr = idx_m1[IDX_W-1:0];
					state_d   = S_UPWR;
				end
			end
			S_UPWR: begin
				req.we  = 1'b1;
				idx_d   = idx_m1;
				state_d = S_UPRD;
			end
			S_DNRD: begin
				if (idx_inc >= {1'b0, cnt_q}) begin
					cnt_d   = cnt_m1;
					state_d = S_DONE;
				end else begin
					req.raddr = idx_inc[IDX_W-1:0];
					state_d   = S_DNWR;
				end
			end
			S_DNWR: begin
				req.we  = 1'b1;
				idx_d   = idx_inc[CNT_W-1:0];
				state_d = S_DNRD;
			end
			S_DONE: begin
				if (done_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign done_valid = (state_q == S_DONE);
	assign res        = '{status: status_q, key: kout_q, item: iout_q, total: cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		func_q   <= func_d;
		key_q    <= key_d;
		item_q   <= item_d;
		kout_q   <= kout_d;
		iout_q   <= iout_d;
		status_q <= status_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !req.we)
		else $error("memory write outside an operation");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && state_q == S_IDLE && cnt_full &&
		 (func == FN_PREPEND || func == FN_APPEND || func == FN_INSERT))
		|=> (state_q == S_DONE && status_q == ST_FULL))
		else $error("insert on full list not rejected");

	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_UPRD || $past(state_q) == S_DNRD))
		else $error("entry count changed outside commit");

endmodule

### test/sorted_key_priority_list_checker.sv
`timescale 1ns / 100ps

module sorted_key_priority_list_checker
	import skpl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [2:0]              func,
	input  logic signed [KEY_W-1:0] key_in,
	input  logic [ITEM_W-1:0]       item_in,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [1:0]              status,
	input  logic signed [KEY_W-1:0] key_out,
	input  logic [ITEM_W-1:0]       item_out,
	input  logic [CNT_W-1:0]        entry_total,
	output int                      fail_count,
	output int                      owed_count
);

	logic signed [KEY_W-1:0] key_mirror [CAPACITY];
	logic [ITEM_W-1:0]       item_mirror [CAPACITY];
	int                      mirror_count = 0;
	res_t                    owed_q [$];

	initial begin
		fail_count = 0;
		owed_count = 0;
	end

	function automatic res_t apply_list_op(input logic [2:0] op,
			input logic signed [KEY_W-1:0] key, input logic [ITEM_W-1:0] item);
		res_t                    r;
		int                      pos;
		logic signed [KEY_W-1:0] new_key;
		r = '0;
		r.status = ST_OK;
		pos = 0;
		new_key = key;
		case (op) inside
			FN_PREPEND, FN_APPEND, FN_INSERT: begin
				if (mirror_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					if (op == FN_PREPEND) begin
						new_key = '0;
						if (mirror_count > 0)
							new_key = (key_mirror[0] == KEY_MIN) ? KEY_MIN : key_mirror[0] - 1;
					end else if (op == FN_APPEND) begin
						new_key = '0;
						pos = mirror_count;
						if (mirror_count > 0)
							new_key = (key_mirror[mirror_count-1] == KEY_MAX) ? KEY_MAX :
								key_mirror[mirror_count-1] + 1;
					end else begin
						while (pos < mirror_count && key_mirror[pos] < key)
							pos++;
					end
					for (int i = mirror_count; i > pos; i--) begin
						key_mirror[i] = key_mirror[i-1];
						item_mirror[i] = item_mirror[i-1];
					end
					key_mirror[pos] = new_key;
					item_mirror[pos] = item;
					mirror_count++;
					r.key = new_key;
				end
			end
			FN_RMHEAD, FN_REMOVE: begin
				if (op == FN_REMOVE)
					while (pos < mirror_count && key_mirror[pos] < key)
						pos++;
				if (pos >= mirror_count || (op == FN_REMOVE && key_mirror[pos] != key)) begin
					r.status = ST_MISS;
				end else begin
					r.key = key_mirror[pos];
					r.item = item_mirror[pos];
					for (int i = pos; i + 1 < mirror_count; i++) begin
						key_mirror[i] = key_mirror[i+1];
						item_mirror[i] = item_mirror[i+1];
					end
					mirror_count--;
				end
			end
			default: begin
			end
		endcase
		r.total = CNT_W'(mirror_count);
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {status, key_out, item_out, entry_total};
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected word status %0h key %0h item %0h total %0d",
						$time, got.status, got.key, got.item, got.total);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					flag_field("status", 32'(want.status), 32'(got.status));
					flag_field("key_out", want.key, got.key);
					flag_field("item_out", want.item, got.item);
					flag_field("entry_total", 32'(want.total), 32'(got.total));
				end
			end
			if (in_valid && in_ready)
				owed_q.push_back(apply_list_op(func, key_in, item_in));
			owed_count <= owed_q.size();
		end
	end

endmodule

### test/sorted_key_priority_list_tb.sv
`timescale 1ns / 100ps

module sorted_key_priority_list_tb;
	import skpl_pkg::*;

	localparam int WORDS       = 700;
	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] FN_UNUSED = 3'd7;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [2:0]              func = FN_PREPEND;
	logic signed [KEY_W-1:0] key_in = '0;
	logic [ITEM_W-1:0]       item_in = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              status;
	logic signed [KEY_W-1:0] key_out;
	logic [ITEM_W-1:0]       item_out;
	logic [CNT_W-1:0]        entry_total;
	int                      fail_count;
	int                      owed_count;
	int                      idle_cycles = 0;
	int                      tx_left = 0;
	bit                      tx_eager = 1'b0;
	int                      mode_left = 0;
	bit                      fill_mode = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sorted_key_priority_list uut (.*);

	sorted_key_priority_list_checker mon (.*);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(input logic [2:0] op, input logic signed [KEY_W-1:0] key,
			input logic [ITEM_W-1:0] item);
		int gap;
		if (tx_left == 0) begin
			tx_eager = ($urandom_range(0, 3) == 0);
			tx_left = $urandom_range(10, 40);
		end
		tx_left--;
		gap = tx_eager ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		key_in <= key;
		item_in <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 7))
			0: return KEY_MIN + $urandom_range(0, 1);
			1: return KEY_MAX - $urandom_range(0, 1);
			2, 3: return $urandom;
			default: return $urandom_range(0, 12) - 6;
		endcase
	endfunction

	// alternate growing and shrinking runs to reach both full and empty
	function automatic logic [2:0] pick_op();
		int roll;
		if (mode_left == 0) begin
			fill_mode = !fill_mode;
			mode_left = $urandom_range(10, 40);
		end
		mode_left--;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return 3'(FN_REMOVE + $urandom_range(1, 3));
		if (fill_mode) begin
			if (roll < 23) return FN_PREPEND;
			if (roll < 43) return FN_APPEND;
			if (roll < 78) return FN_INSERT;
			if (roll < 88) return FN_RMHEAD;
			return FN_REMOVE;
		end
		if (roll < 8) return FN_PREPEND;
		if (roll < 13) return FN_APPEND;
		if (roll < 25) return FN_INSERT;
		if (roll < 60) return FN_RMHEAD;
		return FN_REMOVE;
	endfunction

	initial begin
		int stall;
		int rx_left;
		bit rx_eager;
		rx_left = 0;
		rx_eager = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_left == 0) begin
				rx_eager = ($urandom_range(0, 3) == 0);
				rx_left = $urandom_range(10, 40);
			end
			rx_left--;
			stall = rx_eager ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(FN_RMHEAD, '0, $urandom);
		send(FN_REMOVE, '0, $urandom);
		send(FN_APPEND, $urandom, $urandom);
		send(FN_PREPEND, $urandom, $urandom);
		send(FN_INSERT, KEY_MIN, '1);
		send(FN_PREPEND, KEY_MAX, '0);
		send(FN_INSERT, KEY_MAX, '0);
		send(FN_APPEND, KEY_MIN, '1);
		send(FN_INSERT, 5, 32'h0000_00a5);
		send(FN_INSERT, 5, 32'h0000_00b5);
		send(FN_REMOVE, 5, '1);
		send(FN_REMOVE, 7, '0);
		send(FN_UNUSED, KEY_MAX, '1);
		repeat (9) send(FN_APPEND, $urandom, $urandom);
		send(FN_PREPEND, $urandom, $urandom);
		send(FN_APPEND, $urandom, $urandom);
		send(FN_INSERT, '0, $urandom);

		repeat (WORDS - 25) send(pick_op(), pick_key(), $urandom);
		in_valid <= 1'b0;

		// drain outstanding words, then hold for the longest walk
		@(posedge clk);
		while (owed_count != 0) @(posedge clk);
		repeat (48) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
